// ===== rtl/core/becl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// becl_pkg
// shared sizes, types and result codes of the edge component labeler
// ----------------------------------------------------------------------------
package becl_pkg;

  localparam int LEFT_NODES  = 4096;
  localparam int RIGHT_NODES = 4096;
  localparam int EDGE_SLOTS  = 65536;
  localparam int LABEL_SLOTS = ((LEFT_NODES < RIGHT_NODES) ? LEFT_NODES : RIGHT_NODES) + 1;
  localparam int NODE_MAX    = (LEFT_NODES > RIGHT_NODES) ? LEFT_NODES : RIGHT_NODES;

  localparam int NODE_W  = 12;
  localparam int LABEL_W = 13;
  localparam int SLOT_W  = 16;
  localparam int OUTC_W  = 2;
  localparam int STEP_W  = $clog2(EDGE_SLOTS + 1);
  localparam int CLR_W   = $clog2(NODE_MAX);

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [LABEL_W-1:0] label_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [OUTC_W-1:0]  outc_t;

  localparam outc_t OUTC_NEW    = 2'd0;
  localparam outc_t OUTC_JOINED = 2'd1;
  localparam outc_t OUTC_MERGED = 2'd2;
  localparam outc_t OUTC_REJECT = 2'd3;

endpackage : becl_pkg
`default_nettype wire

// ===== rtl/core/becl_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// becl_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module becl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule : becl_ram
`default_nettype wire

// ===== rtl/core/bipartite_edge_component_labeler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bipartite_edge_component_labeler
// labels connected components of a bipartite graph from a stream of edges
// ----------------------------------------------------------------------------
// latency depends on the outcome: reject goes to OUT, new passes DECIDE,
// joined adds J_WAIT and J_WR, merged adds M_WAIT, M_LINK, a W_WAIT/W_DAT
// pair per edge of the relabeled list (incl. the new one; both edge rams are
// read at one address), then HN_WAIT, HN_WR and HO_CLR; the next request is
// taken once the current result is registered; reset: the left and right label
// stores are cleared one entry a cycle, with in_stall high until done
module bipartite_edge_component_labeler (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire becl_pkg::node_t in_left_node,
  input  wire becl_pkg::node_t in_right_node,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output becl_pkg::label_t     out_component,
  output becl_pkg::outc_t      out_outcome,
  output becl_pkg::slot_t      out_edge_slot,
  output becl_pkg::label_t     out_highest_component
);
  import becl_pkg::*;

  localparam int LAW = $clog2(LEFT_NODES);
  localparam int RAW = $clog2(RIGHT_NODES);
  localparam int HAW = $clog2(LABEL_SLOTS);
  localparam int EAW = $clog2(EDGE_SLOTS);

  localparam logic [3:0] ST_CLR     = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_DECIDE  = 4'd2;
  localparam logic [3:0] ST_J_WAIT  = 4'd3;
  localparam logic [3:0] ST_J_WR    = 4'd4;
  localparam logic [3:0] ST_M_WAIT  = 4'd5;
  localparam logic [3:0] ST_M_LINK  = 4'd6;
  localparam logic [3:0] ST_W_WAIT  = 4'd7;
  localparam logic [3:0] ST_W_DAT   = 4'd8;
  localparam logic [3:0] ST_HN_WAIT = 4'd9;
  localparam logic [3:0] ST_HN_WR   = 4'd10;
  localparam logic [3:0] ST_HO_CLR  = 4'd11;
  localparam logic [3:0] ST_OUT     = 4'd12;

  logic [3:0]       state_r, state_nxt;
  logic [CLR_W-1:0] clr_r, clr_nxt;
  node_t            li_r, li_nxt, rj_r, rj_nxt;
  slot_t            slot_r, slot_nxt, es_r, es_nxt, e_r, e_nxt;
  label_t           top_r, top_nxt, hrd_r, hrd_nxt;
  label_t           newco_r, newco_nxt, oldco_r, oldco_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  label_t           res_comp_r, res_comp_nxt;
  outc_t            res_outc_r, res_outc_nxt;
  slot_t            res_slot_r, res_slot_nxt;
  logic             out_valid_r, out_valid_nxt;
  label_t           out_comp_r, out_comp_nxt, out_top_r, out_top_nxt;
  outc_t            out_outc_r, out_outc_nxt;
  slot_t            out_slot_r, out_slot_nxt;

  logic   ll_we, rl_we, hd_we, en_we, lk_we;
  node_t  ll_waddr, rl_waddr;
  label_t ll_wdata, rl_wdata, ll_rdata, rl_rdata;
  label_t hd_waddr;
  slot_t  hd_wdata, hd_rdata;
  slot_t  en_waddr, lk_waddr, lk_wdata, lk_rdata;
  logic [2*NODE_W-1:0] en_wdata, en_rdata;

  logic   accept, reject, new_lab_ok, hrd_ok;
  label_t ico, jco, lab, new_lab;
  slot_t  hval, nx;
  node_t  wa, wb;

  becl_ram #(.WIDTH(LABEL_W), .DEPTH(LEFT_NODES)) u_left_label (
    .clk(clk), .we(ll_we), .waddr(ll_waddr[LAW-1:0]), .wdata(ll_wdata),
    .raddr(in_left_node[LAW-1:0]), .rdata(ll_rdata)
  );
  becl_ram #(.WIDTH(LABEL_W), .DEPTH(RIGHT_NODES)) u_right_label (
    .clk(clk), .we(rl_we), .waddr(rl_waddr[RAW-1:0]), .wdata(rl_wdata),
    .raddr(in_right_node[RAW-1:0]), .rdata(rl_rdata)
  );
  becl_ram #(.WIDTH(SLOT_W), .DEPTH(LABEL_SLOTS)) u_comp_head (
    .clk(clk), .we(hd_we), .waddr(hd_waddr[HAW-1:0]), .wdata(hd_wdata),
    .raddr(hrd_r[HAW-1:0]), .rdata(hd_rdata)
  );
  becl_ram #(.WIDTH(2*NODE_W), .DEPTH(EDGE_SLOTS)) u_edge_ends (
    .clk(clk), .we(en_we), .waddr(en_waddr[EAW-1:0]), .wdata(en_wdata),
    .raddr(e_r[EAW-1:0]), .rdata(en_rdata)
  );
  becl_ram #(.WIDTH(SLOT_W), .DEPTH(EDGE_SLOTS)) u_edge_link (
    .clk(clk), .we(lk_we), .waddr(lk_waddr[EAW-1:0]), .wdata(lk_wdata),
    .raddr(e_r[EAW-1:0]), .rdata(lk_rdata)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign reject   = (32'(in_left_node) >= LEFT_NODES) || (32'(in_right_node) >= RIGHT_NODES) ||
                    (32'(es_r) >= EDGE_SLOTS - 1);

  assign ico        = ll_rdata;
  assign jco        = rl_rdata;
  assign lab        = (ico != '0) ? ico : jco;
  assign new_lab    = top_r + label_t'(1);
  assign new_lab_ok = 32'(new_lab) < LABEL_SLOTS;
  assign hrd_ok     = 32'(hrd_r) < LABEL_SLOTS;
  assign hval       = hrd_ok ? hd_rdata : '0;
  assign nx         = lk_rdata;
  assign wa         = en_rdata[2*NODE_W-1:NODE_W];
  assign wb         = en_rdata[NODE_W-1:0];

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    li_nxt       = li_r;
    rj_nxt       = rj_r;
    slot_nxt     = slot_r;
    es_nxt       = es_r;
    e_nxt        = e_r;
    top_nxt      = top_r;
    hrd_nxt      = hrd_r;
    newco_nxt    = newco_r;
    oldco_nxt    = oldco_r;
    steps_nxt    = steps_r;
    res_comp_nxt = res_comp_r;
    res_outc_nxt = res_outc_r;
    res_slot_nxt = res_slot_r;

    ll_we = 1'b0; ll_waddr = li_r; ll_wdata = '0;
    rl_we = 1'b0; rl_waddr = rj_r; rl_wdata = '0;
    hd_we = 1'b0; hd_waddr = hrd_r; hd_wdata = slot_r;
    en_we = 1'b0; en_waddr = slot_r; en_wdata = {li_r, rj_r};
    lk_we = 1'b0; lk_waddr = slot_r; lk_wdata = hval;

    case (state_r)
      ST_CLR: begin
        ll_we    = 32'(clr_r) < LEFT_NODES;
        ll_waddr = node_t'(clr_r);
        rl_we    = 32'(clr_r) < RIGHT_NODES;
        rl_waddr = node_t'(clr_r);
        clr_nxt  = clr_r + CLR_W'(1);
        if (32'(clr_r) == NODE_MAX - 1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          li_nxt = in_left_node;
          rj_nxt = in_right_node;
          if (reject) begin
            res_comp_nxt = '0;
            res_outc_nxt = OUTC_REJECT;
            res_slot_nxt = '0;
            state_nxt    = ST_OUT;
          end else begin
            slot_nxt  = es_r + slot_t'(1);
            es_nxt    = es_r + slot_t'(1);
            state_nxt = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        en_we        = 1'b1;
        res_slot_nxt = slot_r;
        if (ico == '0 && jco == '0) begin
          top_nxt  = new_lab;
          ll_we    = 1'b1;
          ll_wdata = new_lab;
          rl_we    = 1'b1;
          rl_wdata = new_lab;
          hd_we    = new_lab_ok;
          hd_waddr = new_lab;
          lk_we    = 1'b1;
          lk_wdata = '0;
          res_comp_nxt = new_lab;
          res_outc_nxt = OUTC_NEW;
          state_nxt    = ST_OUT;
        end else if (ico == '0 || jco == '0 || ico == jco) begin
          ll_we    = 1'b1;
          ll_wdata = lab;
          rl_we    = 1'b1;
          rl_wdata = lab;
          hrd_nxt  = lab;
          res_comp_nxt = lab;
          res_outc_nxt = OUTC_JOINED;
          state_nxt    = ST_J_WAIT;
        end else begin
          newco_nxt = (ico < jco) ? ico : jco;
          oldco_nxt = (ico < jco) ? jco : ico;
          hrd_nxt   = (ico < jco) ? jco : ico;
          res_comp_nxt = (ico < jco) ? ico : jco;
          res_outc_nxt = OUTC_MERGED;
          state_nxt    = ST_M_WAIT;
        end
      end
      ST_J_WAIT: begin
        state_nxt = ST_J_WR;
      end
      ST_J_WR: begin
        lk_we     = 1'b1;
        hd_we     = hrd_ok;
        state_nxt = ST_OUT;
      end
      ST_M_WAIT: begin
        state_nxt = ST_M_LINK;
      end
      ST_M_LINK: begin
        lk_we     = 1'b1;
        e_nxt     = slot_r;
        steps_nxt = '0;
        state_nxt = ST_W_WAIT;
      end
      ST_W_WAIT: begin
        state_nxt = ST_W_DAT;
      end
      ST_W_DAT: begin
        ll_we     = 32'(wa) < LEFT_NODES;
        ll_waddr  = wa;
        ll_wdata  = newco_r;
        rl_we     = 32'(wb) < RIGHT_NODES;
        rl_waddr  = wb;
        rl_wdata  = newco_r;
        steps_nxt = steps_r + STEP_W'(1);
        if (nx == '0 || 32'(nx) >= EDGE_SLOTS || 32'(steps_r) + 32'd1 >= EDGE_SLOTS) begin
          hrd_nxt   = newco_r;
          state_nxt = ST_HN_WAIT;
        end else begin
          e_nxt     = nx;
          state_nxt = ST_W_WAIT;
        end
      end
      ST_HN_WAIT: begin
        state_nxt = ST_HN_WR;
      end
      ST_HN_WR: begin
        lk_we     = 1'b1;
        lk_waddr  = e_r;
        hd_we     = hrd_ok;
        state_nxt = ST_HO_CLR;
      end
      ST_HO_CLR: begin
        hd_we    = 32'(oldco_r) < LABEL_SLOTS;
        hd_waddr = oldco_r;
        hd_wdata = '0;
        if (oldco_r == top_r) begin
          top_nxt = top_r - label_t'(1);
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_comp_nxt  = out_comp_r;
    out_outc_nxt  = out_outc_r;
    out_slot_nxt  = out_slot_r;
    out_top_nxt   = out_top_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == ST_OUT && (!out_valid_r || !out_stall)) begin
      out_valid_nxt = 1'b1;
      out_comp_nxt  = res_comp_r;
      out_outc_nxt  = res_outc_r;
      out_slot_nxt  = res_slot_r;
      out_top_nxt   = top_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      es_r        <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      es_r        <= es_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    li_r       <= li_nxt;
    rj_r       <= rj_nxt;
    slot_r     <= slot_nxt;
    e_r        <= e_nxt;
    hrd_r      <= hrd_nxt;
    newco_r    <= newco_nxt;
    oldco_r    <= oldco_nxt;
    steps_r    <= steps_nxt;
    res_comp_r <= res_comp_nxt;
    res_outc_r <= res_outc_nxt;
    res_slot_r <= res_slot_nxt;
    out_comp_r <= out_comp_nxt;
    out_outc_r <= out_outc_nxt;
    out_slot_r <= out_slot_nxt;
    out_top_r  <= out_top_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_component         = out_comp_r;
  assign out_outcome           = out_outc_r;
  assign out_edge_slot         = out_slot_r;
  assign out_highest_component = out_top_r;

endmodule : bipartite_edge_component_labeler
`default_nettype wire
